// ----- hw/rtl/plm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

   localparam int ENTRY_W   = 32;
   localparam int MAX_BEATS = 64;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_DELETE  = 2'd1;
   localparam logic [1:0] CMD_SEARCH  = 2'd2;
   localparam logic [1:0] CMD_DISPLAY = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [2:0]                 status;
      logic [5:0]                 found_index;
      logic signed [ENTRY_W-1:0]  entry_value;
      logic                       last;
   } rsp_beat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/plm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface plm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [5:0]        position;
   logic signed [31:0] item_value;

   modport source (output valid, output cmd, output position, output item_value, input ready);
   modport sink   (input valid, input cmd, input position, input item_value, output ready);
endinterface

interface plm_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [5:0]        found_index;
   logic signed [31:0] entry_value;
   logic              last;

   modport source (output valid, output status, output found_index, output entry_value,
                   output last, input ready);
   modport sink   (input valid, input status, input found_index, input entry_value,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/plm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plm_ram #(
   parameter int unsigned DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [AW-1:0]                        wr_addr,
   input  wire logic signed [plm_pkg::ENTRY_W-1:0]   wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [AW-1:0]                        rd_addr,
   output      logic signed [plm_pkg::ENTRY_W-1:0]   rd_data
);

   logic signed [plm_pkg::ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/plm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plm_seq #(
   parameter int unsigned CAPACITY = 64,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   output      logic                                 in_ready,
   input  wire logic [1:0]                           in_cmd,
   input  wire logic [5:0]                           in_pos,
   input  wire logic signed [plm_pkg::ENTRY_W-1:0]   in_val,
   output      logic                                 beat_valid,
   input  wire logic                                 beat_free,
   output      plm_pkg::rsp_beat_type                beat,
   output      logic                                 wr_en,
   output      logic [AW-1:0]                        wr_addr,
   output      logic signed [plm_pkg::ENTRY_W-1:0]   wr_data,
   output      logic                                 rd_en,
   output      logic [AW-1:0]                        rd_addr,
   input  wire logic signed [plm_pkg::ENTRY_W-1:0]   rd_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_USE   = 3'd1;
   localparam logic [2:0] S_DHEAD = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      idx_ff, idx_in;
   logic [1:0]                         cmd_ff, cmd_in;
   logic [5:0]                         pos_ff, pos_in;
   logic signed [plm_pkg::ENTRY_W-1:0] val_ff, val_in;
   logic signed [plm_pkg::ENTRY_W-1:0] removed_ff, removed_in;
   plm_pkg::rsp_beat_type              beat_ff, beat_in;
   logic                               last_entry;

   assign last_entry = (32'(idx_ff) + 32'd1 == 32'(count_ff)) ||
                       (32'(idx_ff) + 32'd1 == 32'(plm_pkg::MAX_BEATS));

   assign beat       = beat_ff;
   assign beat_valid = (state_ff == S_EMIT);
   assign in_ready   = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmd_in     = cmd_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      beat_in    = beat_ff;
      wr_en      = 1'b0;
      wr_addr    = AW'(idx_ff);
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd_in   = in_cmd;
               pos_in   = in_pos;
               val_in   = in_val;
               state_in = S_EMIT;
               beat_in  = '{plm_pkg::ST_BADPOS, 6'd0, '0, 1'b1};
               case (in_cmd)
                  plm_pkg::CMD_INSERT: begin
                     if (32'(count_ff) >= 32'(CAPACITY)) begin
                        beat_in.status = plm_pkg::ST_FULL;
                     end else if (32'(in_pos) == 32'(count_ff)) begin
                        state_in = S_FIN;
                     end else if (32'(in_pos) < 32'(count_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(count_ff - 1'b1);
                        idx_in   = count_ff;
                        state_in = S_USE;
                     end
                  end
                  plm_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        beat_in.status = plm_pkg::ST_EMPTY;
                     end else if (32'(in_pos) < 32'(count_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(in_pos);
                        idx_in   = CW'(in_pos);
                        state_in = S_DHEAD;
                     end
                  end
                  plm_pkg::CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        beat_in = '{plm_pkg::ST_NOTFOUND, 6'd0, in_val, 1'b1};
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = S_USE;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        beat_in.status = plm_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = '0;
                        state_in = S_USE;
                     end
                  end
               endcase
            end
         end
         S_USE: begin
            case (cmd_ff)
               plm_pkg::CMD_INSERT: begin
                  // move entry idx-1 up to idx
                  wr_en = 1'b1;
                  if (32'(idx_ff) == 32'(pos_ff) + 32'd1) begin
                     state_in = S_FIN;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(idx_ff - CW'(2));
                     idx_in  = idx_ff - 1'b1;
                  end
               end
               plm_pkg::CMD_DELETE: begin
                  // move entry idx+1 down to idx
                  wr_en = 1'b1;
                  if (32'(idx_ff) + 32'd2 < 32'(count_ff)) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(idx_ff + CW'(2));
                     idx_in  = idx_ff + 1'b1;
                  end else begin
                     count_in = count_ff - 1'b1;
                     beat_in  = '{plm_pkg::ST_OK, pos_ff, removed_ff, 1'b1};
                     state_in = S_EMIT;
                  end
               end
               plm_pkg::CMD_SEARCH: begin
                  if (rd_data == val_ff) begin
                     beat_in  = '{plm_pkg::ST_OK, 6'(idx_ff), val_ff, 1'b1};
                     state_in = S_EMIT;
                  end else if (32'(idx_ff) + 32'd1 == 32'(count_ff)) begin
                     beat_in  = '{plm_pkg::ST_NOTFOUND, 6'd0, val_ff, 1'b1};
                     state_in = S_EMIT;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(idx_ff + 1'b1);
                     idx_in  = idx_ff + 1'b1;
                  end
               end
               default: begin
                  beat_in  = '{plm_pkg::ST_OK, 6'(idx_ff), rd_data, last_entry};
                  state_in = S_EMIT;
               end
            endcase
         end
         S_DHEAD: begin
            removed_in = rd_data;
            if (32'(idx_ff) + 32'd1 < 32'(count_ff)) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff + 1'b1);
               state_in = S_USE;
            end else begin
               count_in = count_ff - 1'b1;
               beat_in  = '{plm_pkg::ST_OK, pos_ff, rd_data, 1'b1};
               state_in = S_EMIT;
            end
         end
         S_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(pos_ff);
            wr_data  = val_ff;
            count_in = count_ff + 1'b1;
            beat_in  = '{plm_pkg::ST_OK, pos_ff, val_ff, 1'b1};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (beat_free) begin
               if (beat_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(idx_ff + 1'b1);
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_USE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      removed_ff <= removed_in;
      beat_ff    <= beat_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_store.sv -----
// Ordered list of signed 32-bit entries held in a single-port-write, one-read synchronous
// RAM of CAPACITY words; one command is processed at a time. Insert and delete move
// every entry behind the position, one RAM word per cycle. Search reads the entries
// in order until a match or the end of the list. Display reads each entry from RAM,
// then passes it to the output register as a beat, and reads the next entry only once
// the output register is free; at most 64 beats, the last one flagged. The response
// beat sits in an output register, so a stalled sink holds only the beat in flight.
// No clearing pass is needed after reset: only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   plm_req_if.sink    req_ch,
   plm_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(CAPACITY);

   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic signed [plm_pkg::ENTRY_W-1:0] wr_data;
   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic signed [plm_pkg::ENTRY_W-1:0] rd_data;
   logic                               beat_valid;
   logic                               beat_free;
   plm_pkg::rsp_beat_type              beat;
   logic                               rsp_valid_ff, rsp_valid_in;
   plm_pkg::rsp_beat_type              rsp_beat_ff, rsp_beat_in;

   plm_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plm_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_cmd     (req_ch.cmd),
      .in_pos     (req_ch.position),
      .in_val     (req_ch.item_value),
      .beat_valid (beat_valid),
      .beat_free  (beat_free),
      .beat       (beat),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   assign beat_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (beat_valid && beat_free) begin
         rsp_valid_in = 1'b1;
         rsp_beat_in  = beat;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_beat_ff.status;
   assign rsp_ch.found_index = rsp_beat_ff.found_index;
   assign rsp_ch.entry_value = rsp_beat_ff.entry_value;
   assign rsp_ch.last        = rsp_beat_ff.last;

   a_beat_held : assert property (@(posedge clock) disable iff (reset)
      beat_valid && !beat_free |=> beat_valid && $stable(beat))
      else $error("pending beat dropped or altered");

   a_no_rw_clash : assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr != rd_addr)
      else $error("RAM read and write to the same word");

   a_idle_no_beat : assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !beat_valid)
      else $error("command accepted with a beat pending");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == plm_pkg::ST_FULL ||
                       rsp_ch.status == plm_pkg::ST_EMPTY ||
                       rsp_ch.status == plm_pkg::ST_BADPOS)
      |-> rsp_ch.found_index == 6'd0 && rsp_ch.entry_value == '0 && rsp_ch.last)
      else $error("error beat carries payload");

endmodule

`default_nettype wire

// ----- bench/positional_list_store_test.sv -----
`timescale 1ns / 1ps

module positional_list_store_test;

   localparam int LIST_CAPACITY = 64;
   localparam int RANDOM_ITEMS  = 390;
   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 100;

   class list_scoreboard;
      logic signed [31:0]    shadow_entries [LIST_CAPACITY];
      int unsigned           shadow_count;
      int unsigned           peak_count;
      plm_pkg::rsp_beat_type expected_beats [$];
      int unsigned           mismatches;
      int unsigned           beats_seen;

      function new();
         shadow_count = 0;
         peak_count   = 0;
         mismatches   = 0;
         beats_seen   = 0;
      endfunction

      function void push_beat(logic [2:0] status, int unsigned idx,
                              logic signed [31:0] value, logic last);
         plm_pkg::rsp_beat_type b;
         b.status      = status;
         b.found_index = idx[5:0];
         b.entry_value = value;
         b.last        = last;
         expected_beats.push_back(b);
      endfunction

      function void note_command(logic [1:0] cmd, logic [5:0] pos,
                                 logic signed [31:0] val);
         int unsigned i;
         int unsigned n;
         bit          hit;
         logic signed [31:0] removed;
         case (cmd)
            plm_pkg::CMD_INSERT: begin
               if (shadow_count >= LIST_CAPACITY) begin
                  push_beat(plm_pkg::ST_FULL, 0, 0, 1'b1);
               end else if (pos > shadow_count) begin
                  push_beat(plm_pkg::ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  for (i = shadow_count; i > pos; i--)
                     shadow_entries[i] = shadow_entries[i-1];
                  shadow_entries[pos] = val;
                  shadow_count++;
                  push_beat(plm_pkg::ST_OK, pos, val, 1'b1);
               end
            end
            plm_pkg::CMD_DELETE: begin
               if (shadow_count == 0) begin
                  push_beat(plm_pkg::ST_EMPTY, 0, 0, 1'b1);
               end else if (pos >= shadow_count) begin
                  push_beat(plm_pkg::ST_BADPOS, 0, 0, 1'b1);
               end else begin
                  removed = shadow_entries[pos];
                  for (i = pos; i + 1 < shadow_count; i++)
                     shadow_entries[i] = shadow_entries[i+1];
                  shadow_count--;
                  push_beat(plm_pkg::ST_OK, pos, removed, 1'b1);
               end
            end
            plm_pkg::CMD_SEARCH: begin
               hit = 1'b0;
               for (i = 0; i < shadow_count && !hit; i++) begin
                  if (shadow_entries[i] == val) begin
                     push_beat(plm_pkg::ST_OK, i, val, 1'b1);
                     hit = 1'b1;
                  end
               end
               if (!hit)
                  push_beat(plm_pkg::ST_NOTFOUND, 0, val, 1'b1);
            end
            default: begin
               if (shadow_count == 0) begin
                  push_beat(plm_pkg::ST_EMPTY, 0, 0, 1'b1);
               end else begin
                  n = (shadow_count > plm_pkg::MAX_BEATS) ? plm_pkg::MAX_BEATS
                                                          : shadow_count;
                  for (i = 0; i < n; i++)
                     push_beat(plm_pkg::ST_OK, i, shadow_entries[i], (i + 1 == n));
               end
            end
         endcase
         if (shadow_count > peak_count)
            peak_count = shadow_count;
      endfunction

      function void check_beat(plm_pkg::rsp_beat_type got);
         plm_pkg::rsp_beat_type want;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            if (mismatches < 10)
               $display("mismatch: unexpected beat status %0d index %0d value %0d last %0d",
                        got.status, got.found_index, got.entry_value, got.last);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.found_index !== want.found_index ||
             got.entry_value !== want.entry_value || got.last !== want.last) begin
            if (mismatches < 10)
               $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.status, want.found_index, want.entry_value, want.last,
                        got.status, got.found_index, got.entry_value, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   plm_req_if req_ch ();
   plm_rsp_if rsp_ch ();

   positional_list_store #(.CAPACITY(LIST_CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_scoreboard sb;
   bit             sender_burst  = 1'b0;
   bit             hold_request  = 1'b0;
   int unsigned    items_sent    = 0;
   int unsigned    cmd_tally [4] = '{0, 0, 0, 0};
   int unsigned    idle_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(logic [1:0] cmd, logic [5:0] pos, logic signed [31:0] val);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= cmd;
      req_ch.position   <= pos;
      req_ch.item_value <= val;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_command(cmd, pos, val);
      cmd_tally[cmd]++;
      items_sent++;
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic random_item(int unsigned k);
      logic [1:0]         cmd;
      logic [5:0]         pos;
      logic signed [31:0] val;
      int unsigned        roll;
      int unsigned        cnt;
      bit                 grow;
      cnt  = sb.shadow_count;
      grow = ((k / 100) % 2 == 1);
      roll = $urandom_range(0, 99);
      if (roll < 8)
         cmd = plm_pkg::CMD_DISPLAY;
      else if (roll < 30)
         cmd = plm_pkg::CMD_SEARCH;
      else if (roll < 90)
         cmd = grow ? plm_pkg::CMD_INSERT : plm_pkg::CMD_DELETE;
      else
         cmd = grow ? plm_pkg::CMD_DELETE : plm_pkg::CMD_INSERT;

      pos = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 6) != 0) begin
         if (cmd == plm_pkg::CMD_INSERT)
            pos = 6'($urandom_range(0, (cnt > 63) ? 63 : cnt));
         else if (cmd == plm_pkg::CMD_DELETE && cnt > 0)
            pos = 6'($urandom_range(0, cnt - 1));
      end

      val = $urandom;
      if (cmd == plm_pkg::CMD_INSERT && $urandom_range(0, 3) == 0)
         val = $urandom_range(0, 7);
      if (cmd == plm_pkg::CMD_SEARCH) begin
         roll = $urandom_range(0, 9);
         if (roll < 6 && cnt > 0)
            val = sb.shadow_entries[$urandom_range(0, cnt - 1)];
         else if (roll < 8)
            val = $urandom_range(0, 7);
      end
      send_item(cmd, pos, val);
   endtask

   // result side
   initial begin : result_sink
      int unsigned           gap;
      int unsigned           beat_no;
      bit                    hold_done;
      plm_pkg::rsp_beat_type got;
      beat_no      = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = ((beat_no / 50) % 3 == 1) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         got.status      = rsp_ch.status;
         got.found_index = rsp_ch.found_index;
         got.entry_value = rsp_ch.entry_value;
         got.last        = rsp_ch.last;
         sb.check_beat(got);
         beat_no++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL positional_list_store");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned k;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = plm_pkg::CMD_INSERT;
      req_ch.position   = '0;
      req_ch.item_value = '0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corners
      send_item(plm_pkg::CMD_DISPLAY, 6'd0, 32'sd0);
      send_item(plm_pkg::CMD_DELETE, 6'd0, 32'sd0);
      send_item(plm_pkg::CMD_SEARCH, 6'd63, 32'h8000_0000);
      send_item(plm_pkg::CMD_INSERT, 6'd1, 32'sd5);
      // value extremes, insert at head and at count
      send_item(plm_pkg::CMD_INSERT, 6'd0, 32'h7fff_ffff);
      send_item(plm_pkg::CMD_INSERT, 6'd0, 32'h8000_0000);
      send_item(plm_pkg::CMD_INSERT, 6'd2, -32'sd1);
      send_item(plm_pkg::CMD_INSERT, 6'd63, 32'sd9);
      send_item(plm_pkg::CMD_SEARCH, 6'd0, -32'sd1);
      send_item(plm_pkg::CMD_SEARCH, 6'd0, 32'h7fff_ffff);
      send_item(plm_pkg::CMD_SEARCH, 6'd0, 32'sd12345);
      send_item(plm_pkg::CMD_DISPLAY, 6'd63, 32'hffff_ffff);
      send_item(plm_pkg::CMD_DELETE, 6'd3, 32'sd0);
      send_item(plm_pkg::CMD_DELETE, 6'd63, 32'sd0);
      send_item(plm_pkg::CMD_DELETE, 6'd1, 32'sd0);
      // duplicates: search returns the lowest index
      send_item(plm_pkg::CMD_INSERT, 6'd0, 32'sd7);
      send_item(plm_pkg::CMD_INSERT, 6'd0, 32'sd7);
      send_item(plm_pkg::CMD_SEARCH, 6'd0, 32'sd7);
      send_item(plm_pkg::CMD_DELETE, 6'd0, 32'sd0);
      send_item(plm_pkg::CMD_DISPLAY, 6'd0, 32'sd0);
      pause_until_drained();

      // fill to capacity, then the full-list corners
      while (sb.shadow_count < LIST_CAPACITY)
         send_item(plm_pkg::CMD_INSERT, 6'($urandom_range(0, sb.shadow_count)), $urandom);
      send_item(plm_pkg::CMD_INSERT, 6'd63, 32'sd1);
      send_item(plm_pkg::CMD_INSERT, 6'd0, 32'sd1);
      send_item(plm_pkg::CMD_DISPLAY, 6'd0, 32'sd0);
      send_item(plm_pkg::CMD_SEARCH, 6'd0, sb.shadow_entries[LIST_CAPACITY-1]);
      send_item(plm_pkg::CMD_DELETE, 6'd63, 32'sd0);
      send_item(plm_pkg::CMD_DELETE, 6'd63, 32'sd0);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         sender_burst = ((k / 40) % 3 == 2);
         if (k == 150)
            hold_request = 1'b1;
         if (k == 300)
            pause_until_drained();
         random_item(k);
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands: %0d insert, %0d delete, %0d search, %0d display",
               items_sent, cmd_tally[plm_pkg::CMD_INSERT], cmd_tally[plm_pkg::CMD_DELETE],
               cmd_tally[plm_pkg::CMD_SEARCH], cmd_tally[plm_pkg::CMD_DISPLAY]);
      $display("%0d result beats checked, list depth up to %0d, %0d mismatches",
               sb.beats_seen, sb.peak_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
         $display("PASS positional_list_store");
      else
         $display("FAIL positional_list_store");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/plm_pkg.sv
hw/rtl/plm_if.sv
hw/rtl/plm_ram.sv
hw/rtl/plm_seq.sv
hw/rtl/positional_list_store.sv
bench/positional_list_store_test.sv
